[src/sld_pkg.sv]
// Shared types, constants and lookup functions for the status LED breathing dimmer.
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

  // Fixed-point format of the breathing factor
  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned FACTOR_W     = FRAC_BITS + 1;
  localparam int unsigned FACTOR_COUNT = 25;
  localparam int unsigned IDX_W        = 5;

  // Breathe step counter
  localparam int unsigned STEP_COUNT = 48;
  localparam int unsigned STEP_HALF  = STEP_COUNT / 2;
  localparam int unsigned STEP_W     = 6;

  // Item kinds on the input channel
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Breathe modes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_SLOW = 2'd1;
  localparam logic [1:0] MODE_FAST = 2'd2;

  // Highest valid status code
  localparam logic [3:0] STATUS_MAX = 4'd9;

  typedef logic [FACTOR_COUNT-1:0][FACTOR_W-1:0] factor_tab_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       updated;
    logic       bad_status;
  } sld_result_t;

  // Cosine-shaped breathing curve in thousandths, full level down to dark
  localparam int unsigned FACTOR_MILLI [FACTOR_COUNT] = '{
    1000, 996, 983, 962, 933, 897, 854, 804, 750, 691,
    629, 565, 500, 435, 371, 309, 250, 196, 146, 103,
    67, 38, 17, 4, 0
  };

  // Rounded fixed-point factors, worked out at elaboration
  function automatic factor_tab_t build_factors();
    factor_tab_t t;
    for (int i = 0; i < FACTOR_COUNT; i++) begin
      t[i] = FACTOR_W'(((longint'(FACTOR_MILLI[i]) << FRAC_BITS) + 500) / 1000);
    end
    return t;
  endfunction

  localparam factor_tab_t FACTOR_TABLE = build_factors();

  // Color per status code, R in the top byte
  function automatic logic [23:0] color_of(input logic [3:0] status);
    logic [23:0] c;
    case (status)
      4'd0:    c = 24'h0000FF;
      4'd1:    c = 24'hFF00FF;
      4'd2:    c = 24'hFF0000;
      4'd3:    c = 24'h00FF00;
      4'd4:    c = 24'hFFFFFF;
      4'd5:    c = 24'h00FFFF;
      4'd6:    c = 24'hFFA500;
      4'd7:    c = 24'hFFFF00;
      4'd8:    c = 24'h00FFFF;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  // Breathe mode per status code
  function automatic logic [1:0] mode_of(input logic [3:0] status);
    logic [1:0] m;
    case (status)
      4'd3:    m = MODE_SLOW;
      4'd6:    m = MODE_FAST;
      4'd8:    m = MODE_SLOW;
      default: m = MODE_OFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[src/sld_scale.sv]
// Breathing curve lookup and per-channel color scaling.
`timescale 1ns / 1ps
`default_nettype none

module sld_scale (
  input  wire logic [23:0]                  base_color,
  input  wire logic [sld_pkg::STEP_W-1:0]   step,
  output logic      [23:0]                  scaled_color
);

  logic [sld_pkg::STEP_W-1:0]   fold;
  logic [sld_pkg::IDX_W-1:0]    idx;
  logic [sld_pkg::FACTOR_W-1:0] factor;

  // Fold the step counter into a triangle index over the curve
  always_comb begin
    if (step <= sld_pkg::STEP_W'(sld_pkg::STEP_HALF)) begin
      fold = step;
    end else begin
      fold = sld_pkg::STEP_W'(sld_pkg::STEP_COUNT) - step;
    end
    idx    = fold[sld_pkg::IDX_W-1:0];
    factor = sld_pkg::FACTOR_TABLE[idx];
  end

  // One multiplier per channel, truncated and clamped to 8 bits
  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic [sld_pkg::FACTOR_W+7:0] prod;
    logic [8:0]                   lvl;

    always_comb begin
      prod = factor * {{(sld_pkg::FACTOR_W){1'b0}}, base_color[ch*8 +: 8]};
      lvl  = prod[sld_pkg::FRAC_BITS +: 9];
      if (lvl > 9'd255) begin
        scaled_color[ch*8 +: 8] = 8'hFF;
      end else begin
        scaled_color[ch*8 +: 8] = lvl[7:0];
      end
    end
  end

endmodule

`default_nettype wire

[src/sld_ctrl.sv]
// Breathing state registers and per-transaction update logic.
`timescale 1ns / 1ps
`default_nettype none

module sld_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire logic               func,
  input  wire logic [3:0]         status,
  output sld_pkg::sld_result_t    result
);

  logic [23:0]                base_color_r, base_color_nxt;
  logic [1:0]                 mode_r, mode_nxt;
  logic [sld_pkg::STEP_W-1:0] step_r, step_nxt, step_inc;
  logic                       phase_r, phase_nxt;
  logic [23:0]                shown_r, shown_nxt;
  logic [23:0]                scaled_color;
  logic                       updated;
  logic                       bad_status;

  sld_scale u_scale (
    .base_color   (base_color_r),
    .step         (step_r),
    .scaled_color (scaled_color)
  );

  // Step counter wraps at the end of one breath
  always_comb begin
    if (step_r == sld_pkg::STEP_W'(sld_pkg::STEP_COUNT - 1)) begin
      step_inc = '0;
    end else begin
      step_inc = step_r + 1'b1;
    end
  end

  // Next state and result for the item in the input register
  always_comb begin
    base_color_nxt = base_color_r;
    mode_nxt       = mode_r;
    step_nxt       = step_r;
    phase_nxt      = phase_r;
    shown_nxt      = shown_r;
    updated        = 1'b0;
    bad_status     = 1'b0;
    if (func == sld_pkg::FUNC_SET) begin
      if (status > sld_pkg::STATUS_MAX) begin
        bad_status = 1'b1;
      end else begin
        base_color_nxt = sld_pkg::color_of(status);
        mode_nxt       = sld_pkg::mode_of(status);
        step_nxt       = '0;
        phase_nxt      = 1'b0;
        shown_nxt      = sld_pkg::color_of(status);
        updated        = 1'b1;
      end
    end else begin
      case (mode_r)
        sld_pkg::MODE_FAST: begin
          shown_nxt = scaled_color;
          step_nxt  = step_inc;
          updated   = 1'b1;
        end
        sld_pkg::MODE_SLOW: begin
          // slow mode steps on every second tick
          if (!phase_r) begin
            phase_nxt = 1'b1;
          end else begin
            phase_nxt = 1'b0;
            shown_nxt = scaled_color;
            step_nxt  = step_inc;
            updated   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers, written only when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_color_r <= '0;
      mode_r       <= sld_pkg::MODE_OFF;
      step_r       <= '0;
      phase_r      <= 1'b0;
      shown_r      <= '0;
    end else if (fire) begin
      base_color_r <= base_color_nxt;
      mode_r       <= mode_nxt;
      step_r       <= step_nxt;
      phase_r      <= phase_nxt;
      shown_r      <= shown_nxt;
    end
  end

  assign result.red        = shown_nxt[23:16];
  assign result.green      = shown_nxt[15:8];
  assign result.blue       = shown_nxt[7:0];
  assign result.updated    = updated;
  assign result.bad_status = bad_status;

endmodule

`default_nettype wire

[src/status_led_breathe_dimmer.sv]
// Top level of the status LED breathing dimmer: input register, control, result register.
`timescale 1ns / 1ps
`default_nettype none

// Status LED driver with a breathing effect. A transaction with in_tuser = 0 sets the
// status code in in_tdata[3:0] (0..9): it picks a fixed color and breathe mode and shows
// the color at full level; codes above 9 are rejected with bad_status and change nothing.
// A transaction with in_tuser = 1 is one 50 ms tick; fast mode takes a breathe step on
// every tick and slow mode on every second tick, scaling the color along a cosine curve.
// Every input transaction yields exactly one result transaction carrying the drive levels
// now shown plus the updated and bad_status flags. The block accepts one transaction per
// clock while out_tready does not hold it back; each item passes the input register, then
// the result register, which is loaded when the item moves on, and the state registers
// feed the next item directly, so back-to-back items need no gap.
// Backpressure on out_tready stalls the input once both registers hold.
module status_led_breathe_dimmer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [3:0] status, [7:4] zero
  input  wire logic        in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic [1:0]       out_tuser   // [0] updated, [1] bad_status
);

  logic                 in_valid_r, in_valid_nxt;
  logic                 in_func_r;
  logic [3:0]           in_status_r;
  logic                 out_valid_r, out_valid_nxt;
  sld_pkg::sld_result_t out_r;
  sld_pkg::sld_result_t result;
  logic                 out_free;
  logic                 fire;
  logic                 in_take;

  // Handshake: the item moves on when the result register is free
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_func_r   <= in_tuser;
      in_status_r <= in_tdata[3:0];
    end
  end

  sld_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .func   (in_func_r),
    .status (in_status_r),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.blue, out_r.green, out_r.red};
  assign out_tuser  = {out_r.bad_status, out_r.updated};

endmodule

`default_nettype wire

[src/sld_checker.sv]
// Port-level checks for the status LED breathing dimmer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sld_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its content
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A rejected status never writes the drive
  a_bad_not_updated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("rejected status reported as update");

  // Input stalls only when a result is backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // An accepted input is always followed by a valid result
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("accepted input produced no result");

endmodule

bind status_led_breathe_dimmer sld_checker u_sld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[tb/led_drive_checker.sv]
// Checker for the status LED dimmer: watches both channels, predicts drive levels, compares.
`timescale 1ns / 1ps

module led_drive_checker
  import sld_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [3:0] status, [7:4] zero
  input  wire logic        in_tuser,   // [0] func
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  input  wire logic [1:0]  out_tuser,  // [0] updated, [1] bad_status
  output int               fail_count,
  output int               pending
);

  // Breathing curve in thousandths, full level down to dark
  localparam int unsigned CURVE_MILLI [FACTOR_COUNT] = '{
    1000, 996, 983, 962, 933, 897, 854, 804, 750, 691,
    629, 565, 500, 435, 371, 309, 250, 196, 146, 103,
    67, 38, 17, 4, 0
  };

  // Color and breathe mode per status code
  localparam logic [23:0] STATUS_COLOR [10] = '{
    24'h0000FF, 24'hFF00FF, 24'hFF0000, 24'h00FF00, 24'hFFFFFF,
    24'h00FFFF, 24'hFFA500, 24'hFFFF00, 24'h00FFFF, 24'h000000
  };
  localparam logic [1:0] STATUS_MODE [10] = '{
    MODE_OFF, MODE_OFF, MODE_OFF, MODE_SLOW, MODE_OFF,
    MODE_OFF, MODE_FAST, MODE_OFF, MODE_SLOW, MODE_OFF
  };

  // Predicted LED state
  logic [23:0]       base_color;
  logic [1:0]        breathe_mode;
  logic [STEP_W-1:0] breathe_pos;
  logic              tick_phase;
  logic [23:0]       shown_color;

  sld_result_t expected_drive_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // One channel scaled by a fixed-point factor, truncated
  function automatic logic [7:0] dim_channel(input int unsigned factor,
                                             input logic [7:0] level);
    int unsigned v;
    v = (factor * level) >> FRAC_BITS;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // One breathe step: fold the counter into a triangle index and rescale
  function automatic void advance_breath();
    int unsigned pos, idx, factor;
    pos = breathe_pos % STEP_COUNT;
    idx = (pos <= STEP_HALF) ? pos : STEP_COUNT - pos;
    factor = ((CURVE_MILLI[idx % FACTOR_COUNT] << FRAC_BITS) + 500) / 1000;
    shown_color = {dim_channel(factor, base_color[23:16]),
                   dim_channel(factor, base_color[15:8]),
                   dim_channel(factor, base_color[7:0])};
    pos++;
    if (pos >= STEP_COUNT) pos = 0;
    breathe_pos = pos[STEP_W-1:0];
  endfunction

  // Applies one input transaction to the predicted state, returns the expected result
  function automatic sld_result_t predict_drive(input logic func, input logic [3:0] status);
    sld_result_t r;
    r.updated    = 1'b0;
    r.bad_status = 1'b0;
    if (func == FUNC_SET) begin
      if (status > STATUS_MAX) begin
        r.bad_status = 1'b1;
      end else begin
        base_color   = STATUS_COLOR[status];
        breathe_mode = STATUS_MODE[status];
        breathe_pos  = '0;
        tick_phase   = 1'b0;
        shown_color  = base_color;
        r.updated    = 1'b1;
      end
    end else if (breathe_mode == MODE_FAST) begin
      advance_breath();
      r.updated = 1'b1;
    end else if (breathe_mode == MODE_SLOW) begin
      if (!tick_phase) begin
        tick_phase = 1'b1;
      end else begin
        tick_phase = 1'b0;
        advance_breath();
        r.updated = 1'b1;
      end
    end
    r.red   = shown_color[23:16];
    r.green = shown_color[15:8];
    r.blue  = shown_color[7:0];
    return r;
  endfunction

  // Compare results in order, then queue the prediction for a new input transaction
  always @(posedge clk) begin : watch
    sld_result_t want, got;
    if (!rst_n) begin
      base_color   = '0;
      breathe_mode = MODE_OFF;
      breathe_pos  = '0;
      tick_phase   = 1'b0;
      shown_color  = '0;
      expected_drive_q.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.red        = out_tdata[7:0];
        got.green      = out_tdata[15:8];
        got.blue       = out_tdata[23:16];
        got.updated    = out_tuser[0];
        got.bad_status = out_tuser[1];
        if (expected_drive_q.size() == 0) begin
          $error("result transaction with nothing expected: tdata %h tuser %b",
                 out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = expected_drive_q.pop_front();
          if (got.red != want.red) begin
            $error("red: expected %0d, actual %0d", want.red, got.red);
            fail_count++;
          end
          if (got.green != want.green) begin
            $error("green: expected %0d, actual %0d", want.green, got.green);
            fail_count++;
          end
          if (got.blue != want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, got.blue);
            fail_count++;
          end
          if (got.updated != want.updated) begin
            $error("updated: expected %0d, actual %0d", want.updated, got.updated);
            fail_count++;
          end
          if (got.bad_status != want.bad_status) begin
            $error("bad_status: expected %0d, actual %0d", want.bad_status, got.bad_status);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_drive_q.push_back(predict_drive(in_tuser, in_tdata[3:0]));
      pending <= expected_drive_q.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top for the status LED dimmer: clock, reset, stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module tb;
  import sld_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 60;
  localparam int PHASE_ITEMS    = 256;

  // Status codes that start breathing
  localparam logic [3:0] ST_GREEN_SLOW  = 4'd3;
  localparam logic [3:0] ST_ORANGE_FAST = 4'd6;
  localparam logic [3:0] ST_CYAN_SLOW   = 4'd8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = FUNC_SET;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  int fail_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int idle_cycles = 0;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  status_led_breathe_dimmer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  led_drive_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off whenever hold_tog flips
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen  <= hold_tog;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one transaction, wait for it to be taken, then maybe leave a gap
  task automatic send_item(input logic func, input logic [3:0] status);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'b0000, status};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Random runs: mostly a breathing status followed by a long run of ticks
  task automatic run_breathing(input int target);
    int         done;
    int         ticks;
    logic [3:0] status;
    done = 0;
    while (done < target) begin
      if ($urandom_range(0, 99) < 75) begin
        case ($urandom_range(0, 2))
          0:       status = ST_GREEN_SLOW;
          1:       status = ST_ORANGE_FAST;
          default: status = ST_CYAN_SLOW;
        endcase
      end else begin
        status = 4'($urandom_range(0, 15));
      end
      send_item(FUNC_SET, status);
      done++;
      ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(20, 110);
      for (int t = 0; t < ticks && done < target; t++) begin
        // rare rejected code in the middle of a run
        if ($urandom_range(0, 49) == 0) begin
          send_item(FUNC_SET, 4'($urandom_range(10, 15)));
        end else begin
          send_item(FUNC_TICK, 4'($urandom_range(0, 15)));
        end
        done++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tick while dark, rejected codes, every color, fast and slow breathing
    send_item(FUNC_TICK, 4'hF);
    for (int s = 10; s < 16; s++) send_item(FUNC_SET, 4'(s));
    for (int s = 0; s < 10; s++) send_item(FUNC_SET, 4'(s));
    send_item(FUNC_SET, ST_ORANGE_FAST);
    repeat (4) send_item(FUNC_TICK, 4'h0);
    send_item(FUNC_SET, ST_GREEN_SLOW);
    repeat (3) send_item(FUNC_TICK, 4'hA);

    // No idling, with a long hold-off on the result side to fill the pipe
    hold_tog <= ~hold_tog;
    run_breathing(PHASE_ITEMS);

    // Sender idle most of the time
    tx_idle_pct = 74;
    run_breathing(PHASE_ITEMS);

    // Receiver stalling most of the time
    tx_idle_pct = 0;
    rx_stall_pct <= 74;
    run_breathing(PHASE_ITEMS);

    // Both sides idling now and then, one more hold-off
    tx_idle_pct = 19;
    rx_stall_pct <= 19;
    hold_tog <= ~hold_tog;
    run_breathing(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
